@@ hdl/mlcp_pkg.sv @@
// ----------------------------------------------------------------------------
// mlcp_pkg
// Types and constants shared by the memory-load command parser modules.
// ----------------------------------------------------------------------------
package mlcp_pkg;

  typedef enum logic [6:0] {
    PH_ID    = 7'b0000001,
    PH_COUNT = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_SUM   = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  localparam logic [2:0] KIND_ID     = 3'd0;
  localparam logic [2:0] KIND_ADDR   = 3'd1;
  localparam logic [2:0] KIND_LEN    = 3'd2;
  localparam logic [2:0] KIND_DATA   = 3'd3;
  localparam logic [2:0] KIND_SUM    = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  localparam logic [1:0] STAT_OK             = 2'd0;
  localparam logic [1:0] STAT_INCONSISTENT   = 2'd1;
  localparam logic [1:0] STAT_TOO_MANY_BLOCK = 2'd2;
  localparam logic [1:0] STAT_TOO_MUCH_DATA  = 2'd3;

  localparam logic [1:0] REG_MAX_BLOCKS = 2'd0;
  localparam logic [1:0] REG_MAX_DATA   = 2'd1;
  localparam logic [1:0] REG_BYTE_ORDER = 2'd2;

  localparam logic [7:0]  RESET_MAX_BLOCKS = 8'd16;
  localparam logic [15:0] RESET_MAX_DATA   = 16'd1024;
  localparam logic        RESET_BYTE_ORDER = 1'b0;

  localparam logic [2:0] SUM_BYTES = 3'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] result_value;
    logic [7:0]  block_number;
    logic [1:0]  status_code;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [7:0]  max_blocks;
    logic [15:0] max_data;
    logic        byte_order;
  } cfg_t;

  typedef struct packed {
    logic    first_valid;
    result_t first;
    logic    second_valid;
    result_t second;
  } push_t;

endpackage

@@ hdl/mlcp_parser.sv @@
// ----------------------------------------------------------------------------
// mlcp_parser
// Parse state and per-byte decode; produces up to two results per byte.
// ----------------------------------------------------------------------------
module mlcp_parser import mlcp_pkg::*; #(
  parameter int ID_BYTES    = 1,
  parameter int COUNT_BYTES = 1,
  parameter int ADDR_BYTES  = 4,
  parameter int LEN_BYTES   = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  input  cfg_t  cfg,
  output push_t push
);

  localparam logic [2:0] ID_W    = 3'(ID_BYTES);
  localparam logic [2:0] COUNT_W = 3'(COUNT_BYTES);
  localparam logic [2:0] ADDR_W  = 3'(ADDR_BYTES);
  localparam logic [2:0] LEN_W   = 3'(LEN_BYTES);

  phase_t      phase, phase_next;
  logic [2:0]  byte_cnt, byte_cnt_next;
  logic [31:0] acc, acc_next;
  logic [7:0]  blocks_expected, blocks_expected_next;
  logic [7:0]  block_index, block_index_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [16:0] data_total, data_total_next;
  logic [1:0]  error_code, error_code_next;

  logic [31:0] acc_in;
  logic [2:0]  field_width;
  logic [2:0]  cnt_inc;
  logic        field_done;
  logic [7:0]  bi_inc;
  logic [17:0] data_sum;
  logic        field_valid;
  result_t     field_res;
  result_t     status_res;

  always_comb begin
    case (phase)
      PH_ID:    field_width = ID_W;
      PH_COUNT: field_width = COUNT_W;
      PH_ADDR:  field_width = ADDR_W;
      PH_LEN:   field_width = LEN_W;
      default:  field_width = SUM_BYTES;
    endcase
  end

  assign cnt_inc    = byte_cnt + 3'd1;
  assign field_done = cnt_inc >= field_width;
  assign acc_in     = cfg.byte_order ? {acc[23:0], item.byte_value}
                    : (acc | ({24'd0, item.byte_value} << {byte_cnt[1:0], 3'b000}));
  assign bi_inc     = block_index + 8'd1;
  assign data_sum   = {1'b0, data_total} + {2'b00, acc_in[15:0]};

  always_comb begin
    phase_next           = phase;
    byte_cnt_next        = byte_cnt;
    acc_next             = acc;
    blocks_expected_next = blocks_expected;
    block_index_next     = block_index;
    bytes_left_next      = bytes_left;
    data_total_next      = data_total;
    error_code_next      = error_code;
    field_valid          = 1'b0;
    field_res            = '0;
    status_res           = '0;

    if (error_code == STAT_OK) begin
      case (phase)
        PH_ID: begin
          acc_next      = acc_in;
          byte_cnt_next = field_done ? 3'd0 : cnt_inc;
          if (field_done) begin
            field_valid            = 1'b1;
            field_res.result_kind  = KIND_ID;
            field_res.result_value = acc_in;
            acc_next               = '0;
            phase_next             = PH_COUNT;
          end
        end
        PH_COUNT: begin
          acc_next      = acc_in;
          byte_cnt_next = field_done ? 3'd0 : cnt_inc;
          if (field_done) begin
            blocks_expected_next = acc_in[7:0];
            acc_next             = '0;
            if (item.last_byte) begin
              error_code_next = STAT_INCONSISTENT;
            end else if (acc_in[7:0] > cfg.max_blocks) begin
              error_code_next = STAT_TOO_MANY_BLOCK;
            end else begin
              phase_next = (acc_in[7:0] == 8'd0) ? PH_DONE : PH_ADDR;
            end
          end
        end
        PH_ADDR: begin
          acc_next      = acc_in;
          byte_cnt_next = field_done ? 3'd0 : cnt_inc;
          if (field_done) begin
            field_valid            = 1'b1;
            field_res.result_kind  = KIND_ADDR;
            field_res.result_value = acc_in;
            field_res.block_number = block_index;
            acc_next               = '0;
            phase_next             = PH_LEN;
          end
        end
        PH_LEN: begin
          acc_next      = acc_in;
          byte_cnt_next = field_done ? 3'd0 : cnt_inc;
          if (field_done) begin
            field_valid            = 1'b1;
            field_res.result_kind  = KIND_LEN;
            field_res.result_value = {16'd0, acc_in[15:0]};
            field_res.block_number = block_index;
            acc_next               = '0;
            bytes_left_next        = acc_in[15:0];
            if (data_sum >= {2'b00, cfg.max_data}) begin
              error_code_next = STAT_TOO_MUCH_DATA;
            end else begin
              phase_next = (acc_in[15:0] == 16'd0) ? PH_SUM : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          field_valid            = 1'b1;
          field_res.result_kind  = KIND_DATA;
          field_res.result_value = {24'd0, item.byte_value};
          field_res.block_number = block_index;
          data_total_next        = data_total + 17'd1;
          bytes_left_next        = bytes_left - 16'd1;
          if (bytes_left_next == 16'd0) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          acc_next      = acc_in;
          byte_cnt_next = field_done ? 3'd0 : cnt_inc;
          if (field_done) begin
            field_valid            = 1'b1;
            field_res.result_kind  = KIND_SUM;
            field_res.result_value = {16'd0, acc_in[15:0]};
            field_res.block_number = block_index;
            acc_next               = '0;
            block_index_next       = bi_inc;
            phase_next             = (bi_inc >= blocks_expected) ? PH_DONE : PH_ADDR;
          end
        end
        default: begin
          // Any byte after the last block is excess.
          error_code_next = STAT_INCONSISTENT;
        end
      endcase
    end

    if (item.last_byte) begin
      status_res.result_kind  = KIND_STATUS;
      status_res.block_number = block_index_next;
      status_res.last_result  = 1'b1;
      if (error_code_next == STAT_OK && phase_next != PH_DONE) begin
        status_res.status_code = STAT_INCONSISTENT;
      end else begin
        status_res.status_code = error_code_next;
      end
      phase_next           = PH_ID;
      byte_cnt_next        = '0;
      acc_next             = '0;
      blocks_expected_next = '0;
      block_index_next     = '0;
      bytes_left_next      = '0;
      data_total_next      = '0;
      error_code_next      = STAT_OK;
    end
  end

  // The status result always takes the slot after any field result.
  always_comb begin
    push = '0;
    if (take) begin
      if (field_valid) begin
        push.first_valid  = 1'b1;
        push.first        = field_res;
        push.second_valid = item.last_byte;
        push.second       = status_res;
      end else begin
        push.first_valid = item.last_byte;
        push.first       = status_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ID;
      byte_cnt        <= '0;
      acc             <= '0;
      blocks_expected <= '0;
      block_index     <= '0;
      bytes_left      <= '0;
      data_total      <= '0;
      error_code      <= STAT_OK;
    end else if (take) begin
      phase           <= phase_next;
      byte_cnt        <= byte_cnt_next;
      acc             <= acc_next;
      blocks_expected <= blocks_expected_next;
      block_index     <= block_index_next;
      bytes_left      <= bytes_left_next;
      data_total      <= data_total_next;
      error_code      <= error_code_next;
    end
  end

endmodule

@@ hdl/mlcp_out_queue.sv @@
// ----------------------------------------------------------------------------
// mlcp_out_queue
// Small result queue; takes up to two results per cycle and delivers one.
// ----------------------------------------------------------------------------
module mlcp_out_queue import mlcp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  push_t                  push,
  input  logic                   pop,
  output result_t                head,
  output logic [QUEUE_LVL_W-1:0] level
);

  result_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W-1:0] wr_ptr_second;
  logic [QUEUE_LVL_W-1:0] push_count;

  assign wr_ptr_second = wr_ptr + QUEUE_PTR_W'(1);
  assign push_count    = QUEUE_LVL_W'(push.first_valid) + QUEUE_LVL_W'(push.second_valid);
  assign head          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      entries[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      level <= level + push_count - QUEUE_LVL_W'(pop);
    end
  end

endmodule

@@ hdl/memory_load_command_parser.sv @@
// ----------------------------------------------------------------------------
// memory_load_command_parser
// Parses a memory-load command one byte at a time into tagged field results.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------
//   item     | item_valid / item_stall   | item_t: byte_value, last_byte
//   result   | result_valid/result_stall | result_t: kind, value, block, status
//   config   | cfg_write_en              | cfg_index, cfg_data (16 bits)
//
// One byte is accepted per cycle while item_stall is low; its results are registered
// into the result queue. The final byte of a command can yield two results, which
// drain one per cycle while result_stall is low, through a four-entry result queue.
// item_stall rises when the queue has fewer than two free entries.
// Reset clears the parse state and the queue and loads register defaults.
// ----------------------------------------------------------------------------
module memory_load_command_parser import mlcp_pkg::*; #(
  parameter int ID_BYTES    = 1,
  parameter int COUNT_BYTES = 1,
  parameter int ADDR_BYTES  = 4,
  parameter int LEN_BYTES   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t                   cfg;
  push_t                  push;
  logic [QUEUE_LVL_W-1:0] level;
  logic                   item_accept;
  logic                   result_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_blocks <= RESET_MAX_BLOCKS;
      cfg.max_data   <= RESET_MAX_DATA;
      cfg.byte_order <= RESET_BYTE_ORDER;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MAX_BLOCKS: cfg.max_blocks <= cfg_data[7:0];
        REG_MAX_DATA:   cfg.max_data   <= cfg_data;
        REG_BYTE_ORDER: cfg.byte_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item_stall    = level > QUEUE_LVL_W'(QUEUE_DEPTH - 2);
  assign item_accept   = item_valid && !item_stall;
  assign result_valid  = level != '0;
  assign result_accept = result_valid && !result_stall;

  mlcp_parser #(
    .ID_BYTES    (ID_BYTES),
    .COUNT_BYTES (COUNT_BYTES),
    .ADDR_BYTES  (ADDR_BYTES),
    .LEN_BYTES   (LEN_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (item_accept),
    .item (item),
    .cfg  (cfg),
    .push (push)
  );

  mlcp_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (result_accept),
    .head  (result),
    .level (level)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= QUEUE_LVL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    !item_accept |-> (!push.first_valid && !push.second_valid))
    else $error("result pushed without an accepted byte");

  a_second_after_first: assert property (@(posedge clk) disable iff (rst)
    push.second_valid |-> (push.first_valid && push.second.last_result))
    else $error("second result slot misused");

  a_last_gives_status: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.last_byte) |->
      ((push.second_valid && push.second.last_result) ||
       (!push.second_valid && push.first_valid && push.first.last_result)))
    else $error("final byte did not produce a status result");
`endif

endmodule

@@ tb/sv/tb_memory_load_command_parser.sv @@
// ----------------------------------------------------------------------------
// tb_memory_load_command_parser
// Self-checking bench for the memory-load command parser. A short scripted
// sequence covers every result kind and the error statuses, then random
// commands run under several register settings. Every accepted request goes
// through a behavioral parser model, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_memory_load_command_parser import mlcp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_W           = 1;
  localparam int COUNT_W        = 1;
  localparam int ADDR_W         = 4;
  localparam int LEN_W          = 2;
  localparam int CSUM_W         = int'(SUM_BYTES);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int NUM_PHASES     = 5;

  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic        pinned;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [1:0]  status;
  } script_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Model copy of the parse state and the registers.
  phase_t      m_phase;
  logic [2:0]  m_fcnt;
  logic [31:0] m_acc;
  logic [7:0]  m_blk_exp;
  logic [7:0]  m_blk_idx;
  logic [15:0] m_left;
  logic [16:0] m_total;
  logic [1:0]  m_err;
  logic [7:0]  lim_blocks;
  logic [15:0] lim_data;
  logic        big_endian;

  result_t parsed_fields[$];
  result_t newest_field;
  int      fields_this_byte;
  int      consumed;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;

  // Under the reset registers: 16 blocks, 1024 data bytes, little endian.
  script_row_t directed_rows [25] = '{
    '{8'hFF, 1'b0, 1'b1, KIND_ID,     32'h0000_00FF, STAT_OK},
    '{8'h01, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h00, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'hFF, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h80, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h01, 1'b0, 1'b1, KIND_ADDR,   32'h0180_FF00, STAT_OK},
    '{8'h01, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h00, 1'b0, 1'b1, KIND_LEN,    32'd1,         STAT_OK},
    '{8'hFF, 1'b0, 1'b1, KIND_DATA,   32'h0000_00FF, STAT_OK},
    '{8'hAA, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h55, 1'b1, 1'b1, KIND_STATUS, 32'd0,         STAT_OK},
    '{8'h07, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h11, 1'b1, 1'b1, KIND_STATUS, 32'd0,         STAT_INCONSISTENT},
    '{8'h5A, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h11, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h33, 1'b1, 1'b1, KIND_STATUS, 32'd0,         STAT_TOO_MANY_BLOCK},
    '{8'h03, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h01, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h78, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h56, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h34, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h12, 1'b0, 1'b1, KIND_ADDR,   32'h1234_5678, STAT_OK},
    '{8'h00, 1'b0, 1'b0, KIND_ID,     32'd0,         STAT_OK},
    '{8'h04, 1'b0, 1'b1, KIND_LEN,    32'd1024,      STAT_OK},
    '{8'h99, 1'b1, 1'b1, KIND_STATUS, 32'd0,         STAT_TOO_MUCH_DATA}
  };

  memory_load_command_parser #(
    .ID_BYTES    (ID_W),
    .COUNT_BYTES (COUNT_W),
    .ADDR_BYTES  (ADDR_W),
    .LEN_BYTES   (LEN_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_parse();
    m_phase   = PH_ID;
    m_fcnt    = '0;
    m_acc     = '0;
    m_blk_exp = '0;
    m_blk_idx = '0;
    m_left    = '0;
    m_total   = '0;
    m_err     = STAT_OK;
  endfunction

  // Folds one byte into the field being assembled; true once it is complete.
  function automatic bit take_field_byte(logic [7:0] b, int width);
    if (big_endian) begin
      m_acc = {m_acc[23:0], b};
    end else begin
      m_acc = m_acc | (32'(b) << (8 * m_fcnt[1:0]));
    end
    m_fcnt = m_fcnt + 3'd1;
    if (int'(m_fcnt) >= width) begin
      m_fcnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit_field(logic [2:0] kind, logic [31:0] value,
                                     logic [7:0] blk, logic [1:0] status,
                                     logic fin);
    newest_field = '{kind, value, blk, status, fin};
    parsed_fields.push_back(newest_field);
    fields_this_byte++;
  endfunction

  // Returns false for a byte that is dropped because an error is pending.
  function automatic bit parse_model_byte(item_t req);
    logic [15:0] len;
    logic [1:0]  status;
    bit          live;
    live = (m_err == STAT_OK) || req.last_byte;
    fields_this_byte = 0;
    if (m_err == STAT_OK) begin
      case (m_phase)
        PH_ID: begin
          if (take_field_byte(req.byte_value, ID_W)) begin
            emit_field(KIND_ID, m_acc, 8'd0, STAT_OK, 1'b0);
            m_acc = '0;
            m_phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (take_field_byte(req.byte_value, COUNT_W)) begin
            m_blk_exp = m_acc[7:0];
            m_acc = '0;
            if (req.last_byte) begin
              m_err = STAT_INCONSISTENT;
            end else if (m_blk_exp > lim_blocks) begin
              m_err = STAT_TOO_MANY_BLOCK;
            end else begin
              m_phase = (m_blk_exp == 8'd0) ? PH_DONE : PH_ADDR;
            end
          end
        end
        PH_ADDR: begin
          if (take_field_byte(req.byte_value, ADDR_W)) begin
            emit_field(KIND_ADDR, m_acc, m_blk_idx, STAT_OK, 1'b0);
            m_acc = '0;
            m_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          if (take_field_byte(req.byte_value, LEN_W)) begin
            len = m_acc[15:0];
            m_acc = '0;
            emit_field(KIND_LEN, {16'd0, len}, m_blk_idx, STAT_OK, 1'b0);
            m_left = len;
            if (int'(m_total) + int'(len) >= int'(lim_data)) begin
              m_err = STAT_TOO_MUCH_DATA;
            end else begin
              m_phase = (len == 16'd0) ? PH_SUM : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          emit_field(KIND_DATA, {24'd0, req.byte_value}, m_blk_idx, STAT_OK, 1'b0);
          m_total = m_total + 17'd1;
          m_left = m_left - 16'd1;
          if (m_left == 16'd0) m_phase = PH_SUM;
        end
        PH_SUM: begin
          if (take_field_byte(req.byte_value, CSUM_W)) begin
            emit_field(KIND_SUM, {16'd0, m_acc[15:0]}, m_blk_idx, STAT_OK, 1'b0);
            m_acc = '0;
            m_blk_idx = m_blk_idx + 8'd1;
            m_phase = (m_blk_idx >= m_blk_exp) ? PH_DONE : PH_ADDR;
          end
        end
        default: begin
          // Anything after the last block is excess data.
          m_err = STAT_INCONSISTENT;
        end
      endcase
    end
    if (req.last_byte) begin
      status = m_err;
      if (status == STAT_OK && m_phase != PH_DONE) status = STAT_INCONSISTENT;
      emit_field(KIND_STATUS, 32'd0, m_blk_idx, status, 1'b1);
      clear_parse();
    end
    return live;
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind %0d value %h block %0d status %0d last %b",
               what, want.result_kind, want.result_value, want.block_number,
               want.status_code, want.last_result);
      $display("  got kind %0d value %h block %0d status %0d last %b",
               got.result_kind, got.result_value, got.block_number,
               got.status_code, got.last_result);
    end
  endfunction

  function automatic void push_field(ref item_t q[$], input logic [31:0] value,
                                     input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (big_endian) q.push_back(item_t'{value[8*(nbytes-1-i) +: 8], 1'b0});
      else q.push_back(item_t'{value[8*i +: 8], 1'b0});
    end
  endfunction

  task automatic send_request(item_t req);
    while (!steady && $urandom_range(0, 99) < 16) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (parse_model_byte(req)) consumed++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MAX_BLOCKS: lim_blocks = data[7:0];
      REG_MAX_DATA:   lim_data = data;
      REG_BYTE_ORDER: big_endian = data[0];
      default: ;
    endcase
  endtask

  // Every command ends with its status result, so nothing is in flight once
  // the last expected result is out; an idle margin follows.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (parsed_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed commands with random content; some are cut short,
  // padded with excess bytes, replaced by noise, or break a limit.
  task automatic send_random_command();
    item_t cmd[$];
    int    style;
    int    n_blocks;
    int    room;
    int    len;
    int    cut;
    style = $urandom_range(0, 99);
    push_field(cmd, $urandom(), ID_W);
    if (lim_blocks != 8'hFF && $urandom_range(0, 99) < 8) begin
      n_blocks = $urandom_range(int'(lim_blocks) + 1, 255);
    end else begin
      n_blocks = $urandom_range(0, (lim_blocks < 8'd4) ? int'(lim_blocks) : 4);
    end
    push_field(cmd, n_blocks, COUNT_W);
    room = int'(lim_data) - 1;
    if (n_blocks <= int'(lim_blocks)) begin
      for (int blk = 0; blk < n_blocks; blk++) begin
        push_field(cmd, $urandom(), ADDR_W);
        if (room < 0 || $urandom_range(0, 99) < 6) begin
          len = (room >= 0 && $urandom_range(0, 1) == 1) ? room + 1
                                                          : $urandom_range(0, 65535);
          push_field(cmd, len, LEN_W);
          break;
        end
        len = $urandom_range(0, (room < 6) ? room : 6);
        push_field(cmd, len, LEN_W);
        repeat (len) cmd.push_back(item_t'{8'($urandom()), 1'b0});
        push_field(cmd, $urandom(), CSUM_W);
        room -= len;
      end
    end
    if (style < 10) begin
      cut = $urandom_range(1, cmd.size());
      while (cmd.size() > cut) void'(cmd.pop_back());
    end else if (style < 18) begin
      repeat ($urandom_range(1, 3)) cmd.push_back(item_t'{8'($urandom()), 1'b0});
    end else if (style < 24) begin
      cmd.delete();
      repeat ($urandom_range(1, 10)) cmd.push_back(item_t'{8'($urandom()), 1'b0});
    end
    cmd[cmd.size()-1].last_byte = 1'b1;
    foreach (cmd[i]) send_request(cmd[i]);
  endtask

  always @(negedge clk) begin
    result_stall <= !steady && ($urandom_range(0, 99) < 16);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (parsed_fields.size() == 0) begin
        note_mismatch("result with nothing pending", '0, result);
      end else begin
        want = parsed_fields.pop_front();
        if (result.result_kind !== want.result_kind
            || result.result_value !== want.result_value
            || result.block_number !== want.block_number
            || result.status_code !== want.status_code
            || result.last_result !== want.last_result) begin
          note_mismatch("result mismatch", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    result_t     row_field;
    script_row_t row;
    int          quota;
    clear_parse();
    lim_blocks = RESET_MAX_BLOCKS;
    lim_data   = RESET_MAX_DATA;
    big_endian = RESET_BYTE_ORDER;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(item_t'{row.b, row.fin});
      if (row.pinned) begin
        row_field = '{row.kind, row.value, newest_field.block_number, row.status,
                      newest_field.last_result};
        if (fields_this_byte == 0 || newest_field.result_kind !== row.kind
            || newest_field.result_value !== row.value
            || newest_field.status_code !== row.status) begin
          note_mismatch("scripted request", row_field, newest_field);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_reg(REG_MAX_BLOCKS, 16'd255);
          write_reg(REG_MAX_DATA, 16'hFFFF);
          write_reg(REG_BYTE_ORDER, 16'd1);
          quota = 160;
        end
        1: begin
          write_reg(REG_MAX_BLOCKS, 16'd0);
          write_reg(REG_MAX_DATA, 16'd0);
          write_reg(REG_BYTE_ORDER, 16'd0);
          quota = 80;
        end
        2: begin
          write_reg(REG_MAX_BLOCKS, 16'd3);
          write_reg(REG_MAX_DATA, 16'd40);
          write_reg(REG_BYTE_ORDER, 16'd1);
          quota = 170;
        end
        3: begin
          write_reg(REG_MAX_BLOCKS, 16'($urandom_range(1, 8)));
          write_reg(REG_MAX_DATA, 16'($urandom_range(20, 300)));
          write_reg(REG_BYTE_ORDER, 16'($urandom_range(0, 1)));
          quota = 170;
        end
        default: begin
          write_reg(REG_MAX_BLOCKS, 16'(RESET_MAX_BLOCKS));
          write_reg(REG_MAX_DATA, RESET_MAX_DATA);
          write_reg(REG_BYTE_ORDER, 16'(RESET_BYTE_ORDER));
          quota = 170;
        end
      endcase
      @(negedge clk);
      cfg_write_en <= 1'b0;
      // One phase runs with both sides streaming back to back.
      steady = (p == 2);
      consumed = 0;
      while (consumed < quota) send_random_command();
    end

    wait_drained();
    if (mismatches == 0 && parsed_fields.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
